// File: hw/rtl/uesc_pkg.sv
// shared types, character constants and decode helpers for the json string unescaper
package uesc_pkg;

    localparam int MAX_RES = 4;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;

    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BYTE_HT = 8'h09;
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_BS = 8'h08;
    localparam logic [7:0] BYTE_FF = 8'h0C;

    localparam logic [15:0] CODE_ONE_LIMIT = 16'h0080;
    localparam logic [15:0] CODE_TWO_LIMIT = 16'h0800;
    localparam logic [7:0]  LEAD_TWO       = 8'hC0;
    localparam logic [7:0]  LEAD_THREE     = 8'hE0;
    localparam logic [7:0]  CONT_MARK      = 8'h80;

    typedef enum logic [2:0] {
        MODE_SEEK = 3'd0,
        MODE_TEXT = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX  = 3'd3
    } mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       body_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       string_end;
        logic       run_last;
    } out_item_t;

    typedef struct packed {
        logic [2:0]      count;
        logic [3:0][7:0] bytes;
        logic [3:0]      ends;
    } res_set_t;

    typedef struct packed {
        mode_t      mode_next;
        logic [2:0] hex_count_next;
        logic       hold_we;
        res_set_t   res;
    } dec_out_t;

    typedef struct packed {
        mode_t      mode;
        logic       c_valid;
        logic [7:0] c_byte;
        logic       c_end;
        logic       f_valid;
    } step_t;

    function automatic logic [7:0] esc_map(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CH_N:    r = BYTE_LF;
            CH_T:    r = BYTE_HT;
            CH_R:    r = BYTE_CR;
            CH_B:    r = BYTE_BS;
            CH_F:    r = BYTE_FF;
            default: r = c;
        endcase
        return r;
    endfunction

    // {digit seen, digit value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // one byte through the text decoder, with the body end handling
    function automatic step_t text_step(input mode_t mode, input logic [7:0] c,
                                        input logic last);
        step_t s;
        mode_t m;
        s = '0;
        m = MODE_SEEK;
        case (mode)
            MODE_TEXT, MODE_HEX:
            begin
                if (c == CH_QUOTE) begin
                    s.c_valid = 1'b1;
                    s.c_end   = 1'b1;
                    m         = MODE_SEEK;
                end else if (c == CH_BSLASH) begin
                    if (last) begin
                        s.c_valid = 1'b1;
                        s.c_byte  = c;
                        m         = MODE_TEXT;
                    end else begin
                        m = MODE_ESC;
                    end
                end else begin
                    s.c_valid = 1'b1;
                    s.c_byte  = c;
                    m         = MODE_TEXT;
                end
            end
            MODE_ESC:
            begin
                if (c == CH_U) begin
                    m = MODE_HEX;
                end else begin
                    s.c_valid = 1'b1;
                    s.c_byte  = esc_map(c);
                    m         = MODE_TEXT;
                end
            end
            default:
            begin
                m = (c == CH_QUOTE) ? MODE_TEXT : MODE_SEEK;
            end
        endcase
        if (last) begin
            s.f_valid = (m != MODE_SEEK);
            m = MODE_SEEK;
        end
        s.mode = m;
        return s;
    endfunction

endpackage

// File: hw/rtl/json_string_unescaper_top.sv
// top level of the json string unescaper: input register, state, decode and result bank
//
// The block takes one body byte per request and sends decoded string bytes out, one
// result per request on the output side, each with string_end (closing quote or end of
// body, data_byte then 0) and run_last on the last result caused by one input byte.
// A byte passes an input register and then a result register before its first result is
// presented. While the output does not stall, an input byte that yields zero or one result
// does not hold up the input, so plain text streams at one byte per clock; a byte that
// yields several results (a \u escape giving two or three UTF-8 bytes, or an end of body
// that adds string_end) stalls the input while the four-entry result bank drains one
// result per cycle when the output does not stall. There is no clearing pass after reset.
module json_string_unescaper_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_stall,
    input  uesc_pkg::in_item_t   char_req,
    output logic                 dec_valid,
    input  logic                 dec_stall,
    output uesc_pkg::out_item_t  dec_req
);
    import uesc_pkg::*;

    logic            in_full_reg;
    logic            in_full_next;
    in_item_t        in_item_reg;
    mode_t           mode_reg;
    mode_t           mode_next;
    logic [2:0]      hex_count_reg;
    logic [2:0]      hex_count_next;
    logic [3:0][7:0] hex_hold_reg;
    dec_out_t        dec;
    logic            buf_free;
    logic            advance;
    logic            take;

    assign advance    = in_full_reg && buf_free;
    assign char_stall = in_full_reg && !advance;
    assign take       = char_valid && !char_stall;

    uesc_decode u_decode (
        .mode      (mode_reg),
        .hex_count (hex_count_reg),
        .hex_hold  (hex_hold_reg),
        .item      (in_item_reg),
        .dec       (dec)
    );

    uesc_outbuf u_outbuf (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (advance),
        .set   (dec.res),
        .free  (buf_free),
        .valid (dec_valid),
        .stall (dec_stall),
        .item  (dec_req)
    );

    always_comb
    begin
        in_full_next   = in_full_reg;
        mode_next      = mode_reg;
        hex_count_next = hex_count_reg;
        if (take) begin
            in_full_next = 1'b1;
        end else if (advance) begin
            in_full_next = 1'b0;
        end
        if (advance) begin
            mode_next      = dec.mode_next;
            hex_count_next = dec.hex_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_full_reg   <= 1'b0;
            mode_reg      <= MODE_SEEK;
            hex_count_reg <= '0;
        end else begin
            in_full_reg   <= in_full_next;
            mode_reg      <= mode_next;
            hex_count_reg <= hex_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            in_item_reg <= char_req;
        end
        if (advance && dec.hold_we) begin
            hex_hold_reg[hex_count_reg[1:0]] <= in_item_reg.ch;
        end
    end

    // hex count only runs inside a unicode escape
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != MODE_HEX |-> hex_count_reg == 3'd0)
        else $error("hex count nonzero outside unicode escape");

    assert property (@(posedge clk) disable iff (!rst_n)
        hex_count_reg < 3'd4)
        else $error("hex count out of range");

    // end of body always returns to seeking
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.body_end |=> mode_reg == MODE_SEEK)
        else $error("body end did not return to seeking");

    assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> in_full_reg)
        else $error("input stalled with empty input register");

endmodule

// File: hw/rtl/uesc_decode.sv
// decode of one registered request into up to four result bytes and the next state
module uesc_decode (
    input  uesc_pkg::mode_t        mode,
    input  logic [2:0]             hex_count,
    input  logic [3:0][7:0]        hex_hold,
    input  uesc_pkg::in_item_t     item,
    output uesc_pkg::dec_out_t     dec
);
    import uesc_pkg::*;

    always_comb
    begin
        logic [3:0][7:0] hold;
        logic [2:0]      cnt1;
        logic [15:0]     code;
        logic            stop;
        logic [4:0]      hd;
        logic [5:0]      cv;
        logic [5:0][7:0] cb;
        logic [5:0]      ce;
        logic [2:0]      n;
        step_t           sd;
        step_t           s0;
        step_t           s1;
        step_t           s2;

        hold = hex_hold;
        hold[hex_count[1:0]] = item.ch;
        cnt1 = hex_count + 3'd1;

        code = '0;
        stop = 1'b0;
        for (int i = 0; i < 4; i++) begin
            hd = hex_digit(hold[i]);
            if (!stop && hd[4]) begin
                code = {code[11:0], hd[3:0]};
            end else begin
                stop = 1'b1;
            end
        end

        sd = text_step(mode, item.ch, item.body_end);
        s0 = text_step(MODE_TEXT, hold[0], cnt1 == 3'd1);
        s1 = text_step(s0.mode, hold[1], cnt1 == 3'd2);
        s2 = text_step(s1.mode, hold[2], 1'b1);

        cv  = '0;
        cb  = '0;
        ce  = '0;
        dec = '0;
        dec.mode_next      = mode;
        dec.hex_count_next = hex_count;

        case (mode)
            MODE_HEX:
            begin
                dec.hold_we = 1'b1;
                if (cnt1[2]) begin
                    if (code < CODE_ONE_LIMIT) begin
                        cv[0] = 1'b1;
                        cb[0] = code[7:0];
                    end else if (code < CODE_TWO_LIMIT) begin
                        cv[1:0] = 2'b11;
                        cb[0]   = LEAD_TWO | {2'b00, code[11:6]};
                        cb[1]   = CONT_MARK | {2'b00, code[5:0]};
                    end else begin
                        cv[2:0] = 3'b111;
                        cb[0]   = LEAD_THREE | {4'h0, code[15:12]};
                        cb[1]   = CONT_MARK | {2'b00, code[11:6]};
                        cb[2]   = CONT_MARK | {2'b00, code[5:0]};
                    end
                    if (item.body_end) begin
                        cv[3] = 1'b1;
                        ce[3] = 1'b1;
                        dec.mode_next = MODE_SEEK;
                    end else begin
                        dec.mode_next = MODE_TEXT;
                    end
                    dec.hex_count_next = '0;
                end else if (item.body_end) begin
                    // held hex bytes go back through the text decoder
                    cv[0] = s0.c_valid;
                    cb[0] = s0.c_byte;
                    ce[0] = s0.c_end;
                    cv[1] = s0.f_valid;
                    ce[1] = 1'b1;
                    if (cnt1 >= 3'd2) begin
                        cv[2] = s1.c_valid;
                        cb[2] = s1.c_byte;
                        ce[2] = s1.c_end;
                        cv[3] = s1.f_valid;
                        ce[3] = 1'b1;
                    end
                    if (cnt1 == 3'd3) begin
                        cv[4] = s2.c_valid;
                        cb[4] = s2.c_byte;
                        ce[4] = s2.c_end;
                        cv[5] = s2.f_valid;
                        ce[5] = 1'b1;
                    end
                    dec.mode_next      = MODE_SEEK;
                    dec.hex_count_next = '0;
                end else begin
                    dec.mode_next      = MODE_HEX;
                    dec.hex_count_next = cnt1;
                end
            end
            default:
            begin
                cv[0] = sd.c_valid;
                cb[0] = sd.c_byte;
                ce[0] = sd.c_end;
                cv[1] = sd.f_valid;
                ce[1] = 1'b1;
                dec.mode_next = sd.mode;
                if (item.body_end || (mode == MODE_ESC && item.ch == CH_U)) begin
                    dec.hex_count_next = '0;
                end
            end
        endcase

        n = '0;
        for (int i = 0; i < 6; i++) begin
            if (cv[i] && n < 3'(MAX_RES)) begin
                dec.res.bytes[n[1:0]] = ce[i] ? 8'h00 : cb[i];
                dec.res.ends[n[1:0]]  = ce[i];
                n = n + 3'd1;
            end
        end
        dec.res.count = n;
    end

endmodule

// File: hw/rtl/uesc_outbuf.sv
// result register bank that hands out the results of one request one per cycle while not stalled
module uesc_outbuf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  uesc_pkg::res_set_t   set,
    output logic                 free,
    output logic                 valid,
    input  logic                 stall,
    output uesc_pkg::out_item_t  item
);
    import uesc_pkg::*;

    logic [3:0][7:0] data_reg;
    logic [3:0]      end_reg;
    logic [2:0]      left_reg;
    logic [2:0]      left_next;
    logic [1:0]      idx_reg;
    logic [1:0]      idx_next;

    assign valid = (left_reg != 3'd0);
    assign free  = (left_reg == 3'd0) || (left_reg == 3'd1 && !stall);

    assign item.data_byte  = data_reg[idx_reg];
    assign item.string_end = end_reg[idx_reg];
    assign item.run_last   = (left_reg == 3'd1);

    always_comb
    begin
        left_next = left_reg;
        idx_next  = idx_reg;
        if (load) begin
            left_next = set.count;
            idx_next  = '0;
        end else if (valid && !stall) begin
            left_next = left_reg - 3'd1;
            idx_next  = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            left_reg <= '0;
            idx_reg  <= '0;
        end else begin
            left_reg <= left_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            data_reg <= set.bytes;
            end_reg  <= set.ends;
        end
    end

endmodule

// File: tb/json_string_unescaper_top_tb.sv
// testbench for the json string unescaper: random bodies, own decoder prediction, result checks
module json_string_unescaper_top_tb;
    import uesc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 195;
    localparam int DRAIN_CYCLES = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic char_valid = 1'b0;
    logic char_stall;
    in_item_t char_req = '0;
    logic dec_valid;
    logic dec_stall = 1'b0;
    out_item_t dec_req;

    in_item_t char_pending [$];
    out_item_t expected_bytes [$];
    out_item_t byte_run [$];

    // decoder state as seen by the prediction
    mode_t unesc_mode;
    logic [7:0] hex_bytes [4];
    logic [2:0] hex_cnt;

    int errors = 0;
    int cycles = 0;
    int send_gap = 0;
    int send_quiet = 0;
    int stall_left = 0;
    int stall_quiet = 0;
    int directed_items;
    out_item_t want;

    json_string_unescaper_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_req   (char_req),
        .dec_valid  (dec_valid),
        .dec_stall  (dec_stall),
        .dec_req    (dec_req)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
        return -1;
    endfunction

    function automatic logic [7:0] escape_target(input logic [7:0] c);
        case (c)
            CH_N:    return BYTE_LF;
            CH_T:    return BYTE_HT;
            CH_R:    return BYTE_CR;
            CH_B:    return BYTE_BS;
            CH_F:    return BYTE_FF;
            default: return c;
        endcase
    endfunction

    function automatic void add_byte(input logic [7:0] b, input logic fin);
        out_item_t r;
        if (byte_run.size() >= MAX_RES) return;
        r.data_byte = b;
        r.string_end = fin;
        r.run_last = 1'b0;
        byte_run = {byte_run, r};
    endfunction

    // utf-8 encoding of the leading hex digits held for a \u escape
    function automatic void add_utf8();
        logic [15:0] code;
        int v;
        code = '0;
        for (int i = 0; i < 4; i++)
        begin
            v = hex_value(hex_bytes[i]);
            if (v < 0) break;
            code = {code[11:0], v[3:0]};
        end
        if (code < 16'h0080)
        begin
            add_byte(code[7:0], 1'b0);
        end
        else if (code < 16'h0800)
        begin
            add_byte({3'b110, code[10:6]}, 1'b0);
            add_byte({2'b10, code[5:0]}, 1'b0);
        end
        else
        begin
            add_byte({4'b1110, code[15:12]}, 1'b0);
            add_byte({2'b10, code[11:6]}, 1'b0);
            add_byte({2'b10, code[5:0]}, 1'b0);
        end
    endfunction

    function automatic void predict_decode(input in_item_t item);
        logic [7:0] replay [4];
        int count;
        int idx;
        logic [7:0] c;
        logic at_end;
        byte_run.delete();
        replay[0] = item.ch;
        count = 1;
        idx = 0;
        while (idx < count)
        begin
            c = replay[idx];
            at_end = item.body_end && (idx + 1 == count);
            idx++;
            case (unesc_mode)
                MODE_TEXT:
                begin
                    if (c == CH_QUOTE)
                    begin
                        add_byte(8'h00, 1'b1);
                        unesc_mode = MODE_SEEK;
                    end
                    else if (c == CH_BSLASH)
                    begin
                        if (at_end) add_byte(c, 1'b0);
                        else unesc_mode = MODE_ESC;
                    end
                    else
                    begin
                        add_byte(c, 1'b0);
                    end
                end
                MODE_ESC:
                begin
                    if (c == CH_U)
                    begin
                        hex_cnt = '0;
                        unesc_mode = MODE_HEX;
                    end
                    else
                    begin
                        add_byte(escape_target(c), 1'b0);
                        unesc_mode = MODE_TEXT;
                    end
                end
                MODE_HEX:
                begin
                    hex_bytes[hex_cnt[1:0]] = c;
                    hex_cnt = hex_cnt + 3'd1;
                    if (hex_cnt >= 3'd4)
                    begin
                        add_utf8();
                        hex_cnt = '0;
                        unesc_mode = MODE_TEXT;
                    end
                    else if (at_end)
                    begin
                        // body ended inside \u: held bytes go through again as text
                        count = int'(hex_cnt);
                        for (int k = 0; k < 4; k++) replay[k] = hex_bytes[k];
                        idx = 0;
                        hex_cnt = '0;
                        unesc_mode = MODE_TEXT;
                        continue;
                    end
                end
                default:
                begin
                    unesc_mode = (c == CH_QUOTE) ? MODE_TEXT : MODE_SEEK;
                end
            endcase
            if (at_end)
            begin
                if (unesc_mode != MODE_SEEK) add_byte(8'h00, 1'b1);
                unesc_mode = MODE_SEEK;
                hex_cnt = '0;
            end
        end
        if (byte_run.size() > 0) byte_run[byte_run.size() - 1].run_last = 1'b1;
        foreach (byte_run[i]) expected_bytes = {expected_bytes, byte_run[i]};
    endfunction

    task automatic queue_byte(input logic [7:0] c, input logic fin);
        in_item_t it;
        it.ch = c;
        it.body_end = fin;
        char_pending = {char_pending, it};
    endtask

    task automatic queue_text(input string s, input logic fin);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i], fin && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        if (nib < 4'd10) return 8'h30 + nib;
        return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    function automatic logic [15:0] pick_code();
        case ($urandom_range(0, 6))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 16'h7F));
            4, 5:    return 16'($urandom_range(16'h80, 16'h7FF));
            default: return 16'($urandom_range(16'h800, 16'hFFFF));
        endcase
    endfunction

    task automatic queue_random_body();
        logic [7:0] body [$];
        string esc_set;
        logic [15:0] code;
        int nstr;
        int ntok;
        int kind;
        int held;
        esc_set = "\"\\/ntrbf";
        if ($urandom_range(0, 14) == 0)
        begin
            repeat ($urandom_range(1, 4)) body = {body, 8'($urandom_range(0, 255))};
        end
        else
        begin
            if ($urandom_range(0, 3) == 0) body = {body, 8'($urandom_range(0, 255))};
            nstr = $urandom_range(1, 2);
            for (int s = 0; s < nstr; s++)
            begin
                body = {body, CH_QUOTE};
                ntok = $urandom_range(0, 6);
                for (int t = 0; t < ntok; t++)
                begin
                    kind = $urandom_range(0, 9);
                    if (kind < 5)
                    begin
                        body = {body, 8'($urandom_range(0, 255))};
                    end
                    else if (kind < 7)
                    begin
                        body = {body, CH_BSLASH};
                        if ($urandom_range(0, 3) == 0)
                            body = {body, 8'($urandom_range(0, 255))};
                        else
                            body = {body, esc_set[$urandom_range(0, 7)]};
                    end
                    else
                    begin
                        body = {body, CH_BSLASH};
                        body = {body, CH_U};
                        code = pick_code();
                        for (int d = 3; d >= 0; d--)
                        begin
                            if ($urandom_range(0, 11) == 0)
                                body = {body, 8'($urandom_range(0, 255))};
                            else
                                body = {body, hex_char(code[d*4 +: 4],
                                                       1'($urandom_range(0, 1)))};
                        end
                    end
                end
                if (s == nstr - 1 && $urandom_range(0, 3) == 0)
                begin
                    // body ends with the string open, maybe inside an escape
                    kind = $urandom_range(0, 2);
                    if (kind > 0) body = {body, CH_BSLASH};
                    if (kind == 2)
                    begin
                        body = {body, CH_U};
                        held = $urandom_range(0, 3);
                        repeat (held) body = {body, hex_char(4'($urandom_range(0, 15)),
                                                             1'($urandom_range(0, 1)))};
                    end
                end
                else
                begin
                    body = {body, CH_QUOTE};
                    if ($urandom_range(0, 3) == 0) body = {body, 8'($urandom_range(0, 255))};
                end
            end
        end
        foreach (body[i]) queue_byte(body[i], i == body.size() - 1);
    endtask

    // request driver, prediction taken at acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_req <= '0;
            send_gap = 0;
            unesc_mode = MODE_SEEK;
            hex_cnt = '0;
            for (int k = 0; k < 4; k++) hex_bytes[k] = '0;
        end
        else
        begin
            if (char_valid && !char_stall) predict_decode(char_req);
            if (!char_valid || !char_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    char_valid <= 1'b0;
                end
                else if (char_pending.size() > 0)
                begin
                    char_req <= char_pending.pop_front();
                    char_valid <= 1'b1;
                    send_gap = pick_gap(send_quiet);
                end
                else
                begin
                    char_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            dec_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            dec_stall <= 1'b0;
            stall_left = pick_gap(stall_quiet);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && dec_valid && !dec_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected result: data_byte %h string_end %b run_last %b",
                       dec_req.data_byte, dec_req.string_end, dec_req.run_last);
                errors++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (dec_req.string_end !== want.string_end)
                begin
                    $error("string_end: expected %b, got %b", want.string_end,
                           dec_req.string_end);
                    errors++;
                end
                if (!want.string_end && dec_req.data_byte !== want.data_byte)
                begin
                    $error("data_byte: expected %h, got %h", want.data_byte,
                           dec_req.data_byte);
                    errors++;
                end
                if (dec_req.run_last !== want.run_last)
                begin
                    $error("run_last: expected %b, got %b", want.run_last, dec_req.run_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[json_string_unescaper_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        // ignored byte, then a quote that is the final byte while seeking
        queue_byte(8'h00, 1'b0);
        queue_text("\"", 1'b1);
        queue_text("\"", 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_text("\\t\\u20AC", 1'b0);
        // quote taken as a hex byte, no digits gives zero
        queue_text("\\u\"7zz", 1'b0);
        // body ends inside \u
        queue_text("\\uFFF", 1'b1);
        // backslash as the final byte
        queue_text("\"\\", 1'b1);
        directed_items = char_pending.size();
        while (char_pending.size() < directed_items + RANDOM_ITEMS) queue_random_body();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (char_pending.size() > 0 || char_valid || expected_bytes.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("[json_string_unescaper_top] OK");
        else
            $display("[json_string_unescaper_top] ERROR");
        $finish;
    end

endmodule
